@@ hdl/bsp_pkg.sv @@
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared widths, constants and types of the beam steering phase unit.
// ----------------------------------------------------------------------------
package bsp_pkg;

  localparam int POS_W   = 20;
  localparam int OFF_W   = 16;
  localparam int ANG_W   = 15;
  localparam int PHASE_W = 16;
  localparam int PWM_W   = 11;

  // Sine in Q30 with headroom for the CORDIC gain overshoot.
  localparam int SIN_W  = 33;
  localparam int Z_W    = 28;
  localparam int ATAN_W = 25;
  localparam int ITERS  = 16;
  localparam int IDX_W  = 4;
  localparam logic signed [SIN_W-1:0] CORDIC_X0 = 33'sd652032874;

  // Product of position and sine, and the biased (non-negative) dividend.
  localparam int PROD_W = 53;
  localparam int MP_W   = 52;
  localparam int HI_W   = 32;
  localparam int Q_W    = 25;
  localparam int REM_W  = 29;
  localparam int DIV_W  = 28;
  localparam int RECIP_SH = 39;

  // Wavelength of 8575 um, folded together with the drop from Q30 to 16 bits.
  localparam logic [63:0] DIVISOR = 64'd8575 << (30 - PHASE_W);
  // A whole multiple of the divisor that lifts every product above zero.
  localparam logic [63:0] BIAS_Q  = ((64'd1 << 50) + DIVISOR - 64'd1) / DIVISOR;
  localparam logic [63:0] BIAS    = BIAS_Q * DIVISOR;
  localparam logic [63:0] RECIP   = (64'd1 << (RECIP_SH + MP_W - HI_W)) / DIVISOR;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             last;
  } bsp_side_t;

  function automatic logic [ATAN_W-1:0] atan_step(input logic [IDX_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      4'd0:    v = 25'd18432000;
      4'd1:    v = 25'd10881045;
      4'd2:    v = 25'd5749245;
      4'd3:    v = 25'd2918407;
      4'd4:    v = 25'd1464867;
      4'd5:    v = 25'd733147;
      4'd6:    v = 25'd366663;
      4'd7:    v = 25'd183343;
      4'd8:    v = 25'd91673;
      4'd9:    v = 25'd45837;
      4'd10:   v = 25'd22918;
      4'd11:   v = 25'd11459;
      4'd12:   v = 25'd5730;
      4'd13:   v = 25'd2865;
      4'd14:   v = 25'd1432;
      default: v = 25'd716;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/bsp_sine.sv @@
// ----------------------------------------------------------------------------
// bsp_sine
// Steering angle register and an iterative CORDIC that derives its sine.
// ----------------------------------------------------------------------------
module bsp_sine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [bsp_pkg::ANG_W-1:0]           wr_data,
  output logic                                busy,
  output logic signed [bsp_pkg::SIN_W-1:0]    sine
);
  import bsp_pkg::*;

  logic signed [ANG_W-1:0] angle;
  logic                    load;
  logic [IDX_W-1:0]        idx;
  logic signed [SIN_W-1:0] x, y;
  logic signed [Z_W-1:0]   z;
  logic signed [ANG_W:0]   folded;
  logic signed [SIN_W-1:0] xs, ys;
  logic signed [Z_W-1:0]   at;

  // Angles past ninety degrees are reflected, which keeps the sine.
  always_comb begin
    if (angle > 15'sd9000) begin
      folded = 16'sd18000 - (ANG_W+1)'(angle);
    end else if (angle < -15'sd9000) begin
      folded = -16'sd18000 - (ANG_W+1)'(angle);
    end else begin
      folded = (ANG_W+1)'(angle);
    end
  end

  assign xs = x >>> idx;
  assign ys = y >>> idx;
  assign at = $signed(Z_W'(atan_step(idx)));

  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      load  <= 1'b1;
      busy  <= 1'b1;
      idx   <= '0;
    end else if (wr_en) begin
      angle <= $signed(wr_data);
      load  <= 1'b1;
      busy  <= 1'b1;
    end else if (load) begin
      load <= 1'b0;
      idx  <= '0;
    end else if (busy) begin
      if (idx == IDX_W'(ITERS - 1)) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      x <= CORDIC_X0;
      y <= '0;
      z <= Z_W'(folded) <<< 12;
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

  assign sine = y;

endmodule

@@ hdl/bsp_divider.sv @@
// ----------------------------------------------------------------------------
// bsp_divider
// Pipelined floor division of the product by the wavelength divisor.
// ----------------------------------------------------------------------------
module bsp_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  logic signed [bsp_pkg::PROD_W-1:0]  prod,
  input  bsp_pkg::bsp_side_t                 in_side,
  output logic                               out_valid,
  output logic [bsp_pkg::PHASE_W-1:0]        turns,
  output bsp_pkg::bsp_side_t                 out_side
);
  import bsp_pkg::*;

  logic [4:0]              valid;
  bsp_side_t               side [5];
  logic [MP_W-1:0]         mp1, mp2, mp3;
  logic [63:0]             p1;
  logic [Q_W-1:0]          q3, q4;
  logic [Q_W+DIV_W-1:0]    p3;
  logic [REM_W-1:0]        r4;
  logic [PHASE_W-1:0]      t5;
  logic signed [PROD_W-1:0] biased;
  logic [MP_W-1:0]         diff;
  logic [Q_W-1:0]          qfix;

  assign biased = prod + $signed(BIAS[PROD_W-1:0]);
  assign diff   = mp3 - p3[MP_W-1:0];
  // The reciprocal estimate is low by at most one.
  assign qfix   = q4 + Q_W'(r4 >= DIVISOR[REM_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      for (int i = 1; i < 5; i++) begin
        side[i] <= side[i-1];
      end
      mp1 <= biased[MP_W-1:0];
      mp2 <= mp1;
      p1  <= 64'(mp1[MP_W-1 -: HI_W]) * 64'(RECIP[HI_W-1:0]);
      mp3 <= mp2;
      q3  <= p1[RECIP_SH +: Q_W];
      p3  <= (Q_W+DIV_W)'(p1[RECIP_SH +: Q_W]) * (Q_W+DIV_W)'(DIVISOR[DIV_W-1:0]);
      q4  <= q3;
      r4  <= diff[REM_W-1:0];
      t5  <= qfix[PHASE_W-1:0] - BIAS_Q[PHASE_W-1:0];
    end
  end

  assign out_valid = valid[4];
  assign turns     = t5;
  assign out_side  = side[4];

endmodule

@@ hdl/beam_steering_phase_unit.sv @@
// ----------------------------------------------------------------------------
// beam_steering_phase_unit
// Drive phase of linear phased array elements, one request per unstalled cycle.
// ----------------------------------------------------------------------------
// Results pass the product, divider and output registers to the master side.
// Throughput: one request per cycle unless stalled; seven-stage datapath.
// After reset and after each steering angle write the CORDIC sine unit runs
// its iterations, during which s_axis_tready is low.
// Reset clears the steering angle to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module beam_steering_phase_unit (
  input  logic                        clk,
  input  logic                        rst,
  // Steering angle write, hundredths of a degree, signed.
  input  logic                        cfg_wr_en,
  input  logic [bsp_pkg::ANG_W-1:0]   cfg_wr_data,
  // Request: [19:0] position, [35:20] phase_offset, [39:36] zero.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,
  input  logic                        s_axis_tlast,
  // Result: [15:0] phase_word, [26:16] pwm_width, [31:27] zero.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata,
  output logic                        m_axis_tlast
);
  import bsp_pkg::*;

  logic                     busy;
  logic signed [SIN_W-1:0]  sine;
  logic                     en;
  logic                     take;
  logic                     v1;
  logic signed [PROD_W-1:0] prod;
  bsp_side_t                side1, side_d;
  logic                     valid_d;
  logic [PHASE_W-1:0]       turns;
  logic [PHASE_W-1:0]       phase;
  logic                     last_out;

  // The sine only changes with the angle register, so one CORDIC run per
  // write serves every element that follows.
  bsp_sine u_sine (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_wr_en),
    .wr_data (cfg_wr_data),
    .busy    (busy),
    .sine    (sine)
  );

  // The whole pipeline advances together whenever the output register is
  // empty or being drained, so a stall holds every stage in place.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !busy;
  assign take          = s_axis_tvalid && s_axis_tready;

  // Stage one: position times sine, a Q30 product in micrometres.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod         <= PROD_W'($signed(s_axis_tdata[POS_W-1:0])) * PROD_W'(sine);
      side1.offset <= s_axis_tdata[POS_W +: OFF_W];
      side1.last   <= s_axis_tlast;
    end
  end

  // Stages two to six: floor of the product over the wavelength, giving the
  // phase in turns with sixteen fraction bits.
  bsp_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .prod      (prod),
    .in_side   (side1),
    .out_valid (valid_d),
    .turns     (turns),
    .out_side  (side_d)
  );

  // Stage seven: add the element offset; the sum wraps modulo one turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= valid_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      phase    <= turns + side_d.offset;
      last_out <= side_d.last;
    end
  end

  assign m_axis_tdata = {5'd0, phase[PHASE_W-1 -: PWM_W], phase};
  assign m_axis_tlast = last_out;

endmodule

@@ sim/bsp_checker.sv @@
// ----------------------------------------------------------------------------
// bsp_checker
// Watches both streams of the beam steering phase unit, predicts each result
// from the accepted request and the current steering angle, and compares.
// ----------------------------------------------------------------------------
module bsp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [14:0] cfg_wr_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [15:0] phase_word;
    logic [10:0] pwm_width;
    logic        last_flag;
  } drive_t;

  localparam longint LAMBDA_UM = 8575;

  longint sine_q30;
  drive_t drive_q[$];

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sine in Q30 of an angle in hundredths of a degree.
  function automatic longint cordic_sine(longint a);
    longint atan_c[16];
    longint x, y, z, nx;
    atan_c = '{18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663,
               183343, 91673, 45837, 22918, 11459, 5730, 2865, 1432, 716};
    x = 652032874;
    y = 0;
    if (a > 9000) a = 18000 - a;
    else if (a < -9000) a = -18000 - a;
    z = a * 4096;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i);
        y = y + asr(x, i);
        z -= atan_c[i];
      end else begin
        nx = x + asr(y, i);
        y = y - asr(x, i);
        z += atan_c[i];
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic drive_t steer_phase(logic [39:0] req, logic last);
    longint pos, prod, turns;
    logic [15:0] phase;
    drive_t r;
    pos = longint'($signed(req[19:0]));
    prod = pos * sine_q30;
    if (prod >= 0) turns = prod / LAMBDA_UM;
    else turns = -((-prod + LAMBDA_UM - 1) / LAMBDA_UM);
    turns = turns >>> 14;
    phase = turns[15:0] + req[35:20];
    r.phase_word = phase;
    r.pwm_width = phase[15:5];
    r.last_flag = last;
    return r;
  endfunction

  assign pending = drive_q.size();

  always @(posedge clk) begin
    drive_t got, want;
    int errs;
    errs = 0;
    if (rst) begin
      sine_q30 <= cordic_sine(0);
      drive_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        sine_q30 <= cordic_sine(longint'($signed(cfg_wr_data)));
      end
      if (s_axis_tvalid && s_axis_tready)
        drive_q.push_back(steer_phase(s_axis_tdata, s_axis_tlast));
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[15:0], m_axis_tdata[26:16], m_axis_tlast};
        if (drive_q.size() == 0) begin
          $error("unexpected result %h", m_axis_tdata);
          errs++;
        end else begin
          want = drive_q.pop_front();
          if (got.phase_word !== want.phase_word) begin
            $error("phase_word exp %0d got %0d", want.phase_word, got.phase_word);
            errs++;
          end
          if (got.pwm_width !== want.pwm_width) begin
            $error("pwm_width exp %0d got %0d", want.pwm_width, got.pwm_width);
            errs++;
          end
          if (got.last_flag !== want.last_flag) begin
            $error("last_flag exp %0d got %0d", want.last_flag, got.last_flag);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives steering angles and element requests into the beam steering phase
// unit with random gaps on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module testbench;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [14:0] cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // [19:0] position, [35:20] phase_offset
  logic        s_axis_tlast;   // last_element
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [15:0] phase_word, [26:16] pwm_width
  logic        m_axis_tlast;   // last_flag
  int          fail_count;
  int          pending;
  int          cycle_count;

  beam_steering_phase_unit i_dut (.*);

  bsp_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result-side stall: now and then hold tready low after a result,
  // with long stretches of no stalling at all.
  initial begin
    int gap;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tready && m_axis_tvalid) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
        if (cycle_count % 4000 < 1000) gap = 0;
        if (gap > 0) begin
          m_axis_tready <= 0;
          repeat (gap) @(posedge clk);
          m_axis_tready <= 1;
        end
      end else begin
        m_axis_tready <= 1;
      end
    end
  end

  // Timeout watchdog: items are cheap, so even worst-case stalls stay far
  // below this count.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 200000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Send one request and hold it until the unit accepts it.
  task automatic send_request(logic [19:0] pos, logic [15:0] off, logic last);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, off, pos};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Angle writes happen only when no result is owed and the pipeline has
  // drained; the unit then recomputes its sine behind a low tready.
  task automatic write_angle(logic [14:0] a);
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= a;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic random_requests(int n);
    logic [19:0] pos;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: pos = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
        1: pos = 20'($signed($urandom_range(0, 20000)) - 10000);
        default: pos = 20'($urandom);
      endcase
      send_request(pos, 16'($urandom), ($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    int angles[9];
    angles = '{0, 9000, -9000, 9001, 16383, -16384, 4500, -3000, 17999};
    rst = 1;
    cfg_wr_en = 0;
    cfg_wr_data = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    repeat (10) @(posedge clk);
    rst <= 0;

    // Directed: field extremes at right angles, where the phase lands on or
    // near whole turns and must wrap.
    write_angle(15'd9000);
    send_request(20'h7FFFF, 16'hFFFF, 1);
    send_request(20'h80000, 16'h0000, 0);
    send_request(20'd8575, 16'h0000, 0);
    send_request(-20'sd8575, 16'h0000, 0);
    send_request(20'd0, 16'hFFFF, 1);
    send_request(20'hFFFFF, 16'h8000, 0);
    write_angle(15'(-9000));
    send_request(20'd17150, 16'h0001, 0);
    send_request(20'h7FFFF, 16'h0000, 1);
    send_request(20'h80000, 16'hFFFF, 0);

    // Random requests, a batch per angle setting, the extremes among them; the
    // first write here pauses the sender until every result is back.
    foreach (angles[k]) begin
      write_angle(15'(angles[k]));
      random_requests(95);
    end
    for (int k = 0; k < 4; k++) begin
      write_angle(15'($urandom));
      random_requests(95);
    end

    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ beam_steering_phase_unit.f @@
hdl/bsp_pkg.sv
hdl/bsp_sine.sv
hdl/bsp_divider.sv
hdl/beam_steering_phase_unit.sv
sim/bsp_checker.sv
sim/testbench.sv
